@@ src/cdq_pkg.sv @@
// Shared types and constants for the circular double-ended queue.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package cdq_pkg;

    // Number of store entries built into the block.
    localparam int DEPTH     = 16;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = ADDR_W + 1;
    localparam int WORD_W    = 32;
    localparam int CAP_W     = 5;
    localparam int CAP_RESET = 16;

    typedef enum logic [1:0] {
        FUNC_PUSH_FRONT = 2'd0,
        FUNC_PUSH_REAR  = 2'd1,
        FUNC_POP_FRONT  = 2'd2,
        FUNC_POP_REAR   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_WRITE = 2'd1,
        S_READ  = 2'd2,
        S_OUT   = 2'd3
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic exec;
        logic load_out;
    } t_dp_cmd;

endpackage

@@ src/cdq_ram.sv @@
// Generic RAM with one write port and two registered read ports.
// Stands alone; no package needed.
`timescale 1ns / 1ps

module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]                      o_rdata_a,
    output logic [WIDTH-1:0]                      o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ src/cdq_ctrl.sv @@
// Sequencing controller for the queue: handshakes and datapath commands.
// Depends on cdq_pkg for the state type and the command struct.
`timescale 1ns / 1ps

module cdq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic             o_cfg_ready,
    output cdq_pkg::t_dp_cmd o_cmd
);

    cdq_pkg::t_state r_state;
    cdq_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            in_accept;
    logic            out_free;

    assign in_accept = i_in_valid && (r_state == cdq_pkg::S_IDLE);
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cdq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = cdq_pkg::S_WRITE;
                end
            end
            cdq_pkg::S_WRITE: begin
                n_state = cdq_pkg::S_READ;
            end
            cdq_pkg::S_READ: begin
                n_state = cdq_pkg::S_OUT;
            end
            cdq_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = cdq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cdq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_stall  = 1'b1;
        o_cfg_ready = 1'b0;
        unique case (r_state)
            cdq_pkg::S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cfg_ready   = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            cdq_pkg::S_WRITE: begin
                o_cmd.exec = 1'b1;
            end
            cdq_pkg::S_READ: begin
            end
            cdq_pkg::S_OUT: begin
                o_cmd.load_out = out_free;
            end
            default: begin
            end
        endcase
    end

    assign n_out_valid = o_cmd.load_out || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cdq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_accept_starts_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == cdq_pkg::S_WRITE))
        else $error("accepted word did not move the controller to the write step");

    a_write_then_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cdq_pkg::S_WRITE) |=> (r_state == cdq_pkg::S_READ))
        else $error("write step not followed by the read step");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> o_out_valid)
        else $error("result loaded but output valid not raised");
`endif

endmodule

@@ src/cdq_datapath.sv @@
// Datapath of the queue: capacity, indices, store and the result register.
// Depends on cdq_pkg and instantiates cdq_ram for the store.
`timescale 1ns / 1ps

module cdq_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cdq_pkg::t_dp_cmd            i_cmd,
    input  logic                        i_cfg_we,
    input  logic [cdq_pkg::CAP_W-1:0]   i_cfg_data,
    input  logic [1:0]                  i_func,
    input  logic [cdq_pkg::WORD_W-1:0]  i_value,
    output logic                        o_error,
    output logic                        o_is_empty,
    output logic                        o_is_full,
    output logic [cdq_pkg::WORD_W-1:0]  o_front_word,
    output logic [cdq_pkg::WORD_W-1:0]  o_rear_word
);

    localparam int AW = cdq_pkg::ADDR_W;
    localparam int CW = cdq_pkg::CNT_W;

    function automatic logic [AW-1:0] step_up(input logic [AW-1:0] i, input logic [CW-1:0] cap);
        logic [CW-1:0] nxt;
        nxt = {1'b0, i} + CW'(1);
        step_up = (nxt >= cap) ? '0 : nxt[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] step_down(input logic [AW-1:0] i,
                                                input logic [CW-1:0] cap);
        logic [CW-1:0] top;
        top = cap - CW'(1);
        step_down = ((i == '0) || ({1'b0, i} >= cap)) ? top[AW-1:0] : i - AW'(1);
    endfunction

    logic [cdq_pkg::CAP_W-1:0]  r_cap;
    logic [cdq_pkg::CAP_W-1:0]  n_cap;
    logic [AW-1:0]              r_front;
    logic [AW-1:0]              n_front;
    logic [AW-1:0]              r_rear;
    logic [AW-1:0]              n_rear;
    logic                       r_empty;
    logic                       n_empty;
    logic                       r_err;
    logic                       n_err;
    cdq_pkg::t_func             r_func;
    logic [cdq_pkg::WORD_W-1:0] r_word;
    logic                       r_out_err;
    logic                       r_out_empty;
    logic                       r_out_full;
    logic [cdq_pkg::WORD_W-1:0] r_out_front;
    logic [cdq_pkg::WORD_W-1:0] r_out_rear;

    logic [CW-1:0]              cap_use;
    logic                       full_now;
    logic                       is_push;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [cdq_pkg::WORD_W-1:0] rd_front;
    logic [cdq_pkg::WORD_W-1:0] rd_rear;

    // A capacity of zero behaves as one, anything above the store as the whole store.
    always_comb begin
        if (r_cap == '0) begin
            cap_use = CW'(1);
        end else if (32'(r_cap) > cdq_pkg::DEPTH) begin
            cap_use = CW'(cdq_pkg::DEPTH);
        end else begin
            cap_use = CW'(r_cap);
        end
    end

    assign full_now = !r_empty && (step_up(r_front, cap_use) == r_rear);
    assign is_push  = (r_func == cdq_pkg::FUNC_PUSH_FRONT) ||
                      (r_func == cdq_pkg::FUNC_PUSH_REAR);

    always_comb begin
        n_cap     = r_cap;
        n_front   = r_front;
        n_rear    = r_rear;
        n_empty   = r_empty;
        n_err     = r_err;
        ram_we    = 1'b0;
        ram_waddr = r_front;
        if (i_cmd.exec) begin
            n_err = 1'b0;
            if (is_push) begin
                if (r_empty) begin
                    // First word lands in entry zero whichever end was named.
                    n_front   = '0;
                    n_rear    = '0;
                    n_empty   = 1'b0;
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                end else if (full_now) begin
                    n_err = 1'b1;
                end else if (r_func == cdq_pkg::FUNC_PUSH_FRONT) begin
                    n_front   = step_up(r_front, cap_use);
                    ram_we    = 1'b1;
                    ram_waddr = n_front;
                end else begin
                    n_rear    = step_down(r_rear, cap_use);
                    ram_we    = 1'b1;
                    ram_waddr = n_rear;
                end
            end else begin
                if (r_empty) begin
                    n_err = 1'b1;
                end else if (r_front == r_rear) begin
                    n_front = '0;
                    n_rear  = '0;
                    n_empty = 1'b1;
                end else if (r_func == cdq_pkg::FUNC_POP_FRONT) begin
                    n_front = step_down(r_front, cap_use);
                end else begin
                    n_rear = step_up(r_rear, cap_use);
                end
            end
        end
        if (i_cfg_we) begin
            n_cap   = i_cfg_data;
            n_front = '0;
            n_rear  = '0;
            n_empty = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= cdq_pkg::CAP_W'(cdq_pkg::CAP_RESET);
            r_front <= '0;
            r_rear  <= '0;
            r_empty <= 1'b1;
            r_err   <= 1'b0;
        end else begin
            r_cap   <= n_cap;
            r_front <= n_front;
            r_rear  <= n_rear;
            r_empty <= n_empty;
            r_err   <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_func <= cdq_pkg::t_func'(i_func);
            r_word <= i_value;
        end
        if (i_cmd.load_out) begin
            r_out_err   <= r_err;
            r_out_empty <= r_empty;
            r_out_full  <= full_now;
            r_out_front <= r_empty ? '1 : rd_front;
            r_out_rear  <= r_empty ? '1 : rd_rear;
        end
    end

    cdq_ram #(
        .WIDTH (cdq_pkg::WORD_W),
        .DEPTH (cdq_pkg::DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (r_word),
        .i_raddr_a (r_front),
        .i_raddr_b (r_rear),
        .o_rdata_a (rd_front),
        .o_rdata_b (rd_rear)
    );

    assign o_error      = r_out_err;
    assign o_is_empty   = r_out_empty;
    assign o_is_full    = r_out_full;
    assign o_front_word = r_out_front;
    assign o_rear_word  = r_out_rear;

`ifndef SYNTHESIS
    a_front_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_front} < cap_use) && ({1'b0, r_rear} < cap_use))
        else $error("queue index outside the capacity in use");

    a_last_pop_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && !is_push && !r_empty && (r_front == r_rear) && !i_cfg_we)
        |=> (r_empty && (r_front == '0) && (r_rear == '0)))
        else $error("popping the last word did not empty the queue");
`endif

endmodule

@@ src/circular_double_ended_queue.sv @@
// Top level of the circular double-ended queue of signed 32-bit words.
// Depends on cdq_pkg; instantiates cdq_ctrl and cdq_datapath (which holds cdq_ram).
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Word
// input     in         i_in_valid / o_in_stall   i_func, i_value
// result    out        o_out_valid / i_out_stall o_error, o_is_empty, o_is_full,
//                                                o_front_word, o_rear_word
// config    in         i_cfg_valid / o_cfg_ready i_cfg_data (capacity)
//
// A word's steps are: accept, index update and store write, store read,
// and the load of the result register. The store read is a step of its own because
// the read ports are registered; a result stalled at the output holds the last step.
// Reset is synchronous and active low; it sets the capacity to 16 and the queue
// to empty. The store needs no clearing pass, since only written entries are read.
// A new input word is taken while an earlier result still waits to be taken.

module circular_double_ended_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_func,
    input  logic signed [31:0]         i_value,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_error,
    output logic                       o_is_empty,
    output logic                       o_is_full,
    output logic signed [31:0]         o_front_word,
    output logic signed [31:0]         o_rear_word,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [cdq_pkg::CAP_W-1:0]  i_cfg_data
);

    cdq_pkg::t_dp_cmd           cmd;
    logic                       cfg_we;
    logic [cdq_pkg::WORD_W-1:0] front_word;
    logic [cdq_pkg::WORD_W-1:0] rear_word;

    // The controller only offers the configuration port while it is idle, so a
    // capacity write never lands in the middle of an operation.
    assign cfg_we = i_cfg_valid && o_cfg_ready;

    cdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (cmd)
    );

    // The datapath keeps the capacity, the two indices, the empty mark and the
    // store; a capacity write also empties the queue.
    cdq_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_func       (i_func),
        .i_value      (i_value),
        .o_error      (o_error),
        .o_is_empty   (o_is_empty),
        .o_is_full    (o_is_full),
        .o_front_word (front_word),
        .o_rear_word  (rear_word)
    );

    // Both end words read as all ones when the queue is empty.
    assign o_front_word = signed'(front_word);
    assign o_rear_word  = signed'(rear_word);

endmodule
